### src/ltrm_pkg.sv
// Shared types and constants for the landmark table running-mean unit.
// Used by ltrm_div and landmark_table_running_mean_unit; no dependencies.
package ltrm_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int COUNT_W       = 16;
    localparam int POS_W         = 32;
    localparam int ID_W          = 64;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // running-mean numerator c*old+new, and divisor c+1
    localparam int NUM_W = COUNT_W + POS_W + 1;
    localparam int MAG_W = NUM_W - 1;
    localparam int DEN_W = COUNT_W + 1;

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic signed [ID_W-1:0]  landmark_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic                    inserted;
        logic                    erased;
        logic                    found;
        logic                    table_full;
        logic [COUNT_W-1:0]      new_count;
        logic signed [POS_W-1:0] avg_x;
        logic signed [POS_W-1:0] avg_y;
        logic signed [POS_W-1:0] avg_z;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic [COUNT_W-1:0]      count;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
    } entry_t;

endpackage

### src/ltrm_div.sv
// Bit-serial signed divider for the running mean, one quotient bit per cycle.
// Depends on ltrm_pkg for the numerator and divisor widths.
module ltrm_div
    import ltrm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [POS_W-1:0] quo
);

    localparam int CNT_W = $clog2(MAG_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [MAG_W-1:0]   num_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               neg_reg;
    logic [MAG_W-1:0]   mag;
    logic [DEN_W:0]     trial;
    logic               take;

    assign mag   = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    assign trial = {rem_reg, num_reg[MAG_W-1]};
    assign take  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= mag;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            // restoring step: shift in the next numerator bit, subtract if it fits
            rem_reg <= take ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            num_reg <= {num_reg[MAG_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? POS_W'(-num_reg[POS_W-1:0]) : num_reg[POS_W-1:0];

endmodule

### src/landmark_table_running_mean_unit.sv
// Top level of the landmark table: entry memory, search/erase sequencer, output register.
// Depends on ltrm_pkg and ltrm_div.
//
// Usage: one input transaction (in_valid/in_stall, payload in_data) adds or removes one
// observation of a landmark id; each produces exactly one output transaction
// (out_valid/out_stall, payload out_data). cfg_we/cfg_data write average_enable
// (reset 1); write it only while the unit is idle.
// The table lives in one memory with one write port and one registered read port. The id
// search reads the live entries one at a time, lowest slot first, each through a read
// state and a check state; a hit or a miss then finishes through the result state back
// to idle. An averaging add also takes a multiply step, a divider start step and the
// 48 quotient bits in the three parallel bit-serial dividers.
// An erasing remove shifts each later entry down one slot through a read and a write state.
// One item is in work at a time; in_stall is high while it is processed.
// The finished result sits in an output register, so the next item can be accepted while
// the receiver stalls; a second result waits in the sequencer until the register frees.
// Reset empties the table (live count zero) and needs no clearing pass; memory contents
// are undefined until written and only data read from live slots is ever used.
module landmark_table_running_mean_unit
    import ltrm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int UW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CHECK, S_MISS, S_MUL, S_DSTART, S_DIV,
        S_SH_READ, S_SH_WRITE, S_WRITE, S_DONE
    } state_t;

    state_t                  state_reg;
    logic                    avg_en_reg;
    logic [UW-1:0]           used_reg;
    logic [UW-1:0]           idx_reg;
    in_item_t                item_reg;
    entry_t                  ent_reg;
    out_item_t               res_reg;
    out_item_t               out_data_reg;
    logic                    out_valid_reg;
    logic signed [NUM_W-1:0] numx_reg, numy_reg, numz_reg;

    entry_t                  mem [TABLE_DEPTH];
    entry_t                  mem_q;
    logic                    mem_we;
    logic [IW-1:0]           mem_waddr;
    logic [IW-1:0]           mem_raddr;
    entry_t                  mem_wdata;

    logic [UW-1:0]           idx_inc;
    logic [COUNT_W-1:0]      cnt_sat;
    logic [COUNT_W-1:0]      cnt_dec;
    logic [DEN_W-1:0]        den;
    logic                    div_start;
    logic                    dx_done, dy_done, dz_done;
    logic signed [POS_W-1:0] qx, qy, qz;
    logic signed [NUM_W-1:0] c_ext;
    logic                    res_load;

    assign idx_inc   = idx_reg + 1'b1;
    assign cnt_sat   = (ent_reg.count == COUNT_MAX) ? COUNT_MAX : ent_reg.count + 1'b1;
    assign cnt_dec   = (mem_q.count == '0) ? '0 : mem_q.count - 1'b1;
    assign den       = {1'b0, ent_reg.count} + DEN_W'(1);
    assign div_start = (state_reg == S_DSTART);
    assign c_ext     = NUM_W'($signed({1'b0, ent_reg.count}));
    assign res_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // entry memory, registered read
    assign mem_we    = (state_reg == S_WRITE) || (state_reg == S_SH_WRITE);
    assign mem_waddr = idx_reg[IW-1:0];
    assign mem_wdata = (state_reg == S_SH_WRITE) ? mem_q : ent_reg;
    assign mem_raddr = (state_reg == S_SH_READ) ? idx_inc[IW-1:0] : idx_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    ltrm_div u_div_x (.clk(clk), .rst_n(rst_n), .start(div_start), .num(numx_reg),
                      .den(den), .done(dx_done), .quo(qx));
    ltrm_div u_div_y (.clk(clk), .rst_n(rst_n), .start(div_start), .num(numy_reg),
                      .den(den), .done(dy_done), .quo(qy));
    ltrm_div u_div_z (.clk(clk), .rst_n(rst_n), .start(div_start), .num(numz_reg),
                      .den(den), .done(dz_done), .quo(qz));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            avg_en_reg    <= 1'b1;
            used_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                avg_en_reg <= cfg_data;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        idx_reg   <= '0;
                        state_reg <= (used_reg == '0) ? S_MISS : S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (mem_q.id == item_reg.landmark_id)
                    begin
                        if (item_reg.mode == MODE_ADD)
                        begin
                            ent_reg   <= mem_q;
                            state_reg <= avg_en_reg ? S_MUL : S_DIV;
                        end
                        else if (cnt_dec == '0)
                        begin
                            res_reg   <= '{erased: 1'b1, found: 1'b1, default: '0};
                            state_reg <= S_SH_READ;
                        end
                        else
                        begin
                            ent_reg   <= '{id: mem_q.id, count: cnt_dec, px: mem_q.px,
                                           py: mem_q.py, pz: mem_q.pz};
                            res_reg   <= '{found: 1'b1, new_count: cnt_dec,
                                           avg_x: mem_q.px, avg_y: mem_q.py,
                                           avg_z: mem_q.pz, default: '0};
                            state_reg <= S_WRITE;
                        end
                    end
                    else if (idx_inc == used_reg)
                    begin
                        state_reg <= S_MISS;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_READ;
                    end
                end
                S_MISS:
                begin
                    if (item_reg.mode == MODE_REMOVE)
                    begin
                        res_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else if (used_reg == UW'(TABLE_DEPTH))
                    begin
                        res_reg   <= '{table_full: 1'b1, default: '0};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ent_reg   <= '{id: item_reg.landmark_id, count: COUNT_W'(1),
                                       px: item_reg.pos_x, py: item_reg.pos_y,
                                       pz: item_reg.pos_z};
                        res_reg   <= '{inserted: 1'b1, new_count: COUNT_W'(1),
                                       avg_x: item_reg.pos_x, avg_y: item_reg.pos_y,
                                       avg_z: item_reg.pos_z, default: '0};
                        idx_reg   <= used_reg;
                        used_reg  <= used_reg + 1'b1;
                        state_reg <= S_WRITE;
                    end
                end
                S_MUL:
                begin
                    numx_reg  <= c_ext * NUM_W'(ent_reg.px) + NUM_W'(item_reg.pos_x);
                    numy_reg  <= c_ext * NUM_W'(ent_reg.py) + NUM_W'(item_reg.pos_y);
                    numz_reg  <= c_ext * NUM_W'(ent_reg.pz) + NUM_W'(item_reg.pos_z);
                    state_reg <= S_DSTART;
                end
                S_DSTART:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // without averaging this state passes straight through
                    if (!avg_en_reg || dx_done)
                    begin
                        if (avg_en_reg)
                        begin
                            ent_reg <= '{id: ent_reg.id, count: cnt_sat,
                                         px: qx, py: qy, pz: qz};
                            res_reg <= '{found: 1'b1, new_count: cnt_sat,
                                         avg_x: qx, avg_y: qy, avg_z: qz, default: '0};
                        end
                        else
                        begin
                            ent_reg <= '{id: ent_reg.id, count: cnt_sat, px: ent_reg.px,
                                         py: ent_reg.py, pz: ent_reg.pz};
                            res_reg <= '{found: 1'b1, new_count: cnt_sat,
                                         avg_x: ent_reg.px, avg_y: ent_reg.py,
                                         avg_z: ent_reg.pz, default: '0};
                        end
                        state_reg <= S_WRITE;
                    end
                end
                S_SH_READ:
                begin
                    if (idx_inc >= used_reg)
                    begin
                        used_reg  <= used_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SH_WRITE;
                    end
                end
                S_SH_WRITE:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_SH_READ;
                end
                S_WRITE:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold the result until the output register is free
                    if (res_load)
                    begin
                        out_data_reg <= res_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(TABLE_DEPTH))
        else $error("live entry count exceeds table depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != S_IDLE)
        else $error("accepted transaction not taken into work");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        dx_done |-> state_reg == S_DIV)
        else $error("divider finished outside its wait state");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SH_WRITE |-> idx_inc < used_reg)
        else $error("erase shift beyond live entries");

    a_div_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        dx_done == dy_done && dx_done == dz_done)
        else $error("divider lanes out of step");

endmodule
